### hw/rtl/rmrpy_pkg.sv
// rmrpy_pkg: shared constants, types and the arctangent table for the
// rotation matrix to roll/pitch/yaw pipeline. Depends on nothing.
package rmrpy_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MW       = 16;   // matrix element width, Q2.14
  localparam int OW       = 16;   // angle width, Q3.13
  localparam int IW       = 33;   // cordic operand width, Q2.30 plus headroom
  localparam int DW       = 36;   // cordic x/y datapath width
  localparam int ZW       = 35;   // cordic angle accumulator width, Q5.30
  localparam int SUMSQ_W  = 32;
  localparam int ROOT_W   = 32;
  localparam int REM_W    = 34;
  localparam int ISQ_STEPS = 32;  // one root bit per stage

  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [OW-1:0] PI_Q13      = 16'sd25736;
  localparam logic signed [OW-1:0] HALF_PI_Q13 = 16'sd12868;

  // atan(2^-i) in Q2.30, truncated
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  // matrix elements carried alongside the square root
  typedef struct packed {
    logic signed [MW-1:0] m00;
    logic signed [MW-1:0] m10;
    logic signed [MW-1:0] m20;
    logic signed [MW-1:0] m21;
    logic signed [MW-1:0] m22;
  } mrow_t;

endpackage

### hw/rtl/rmrpy_isqrt.sv
// rmrpy_isqrt: pipelined floor square root of sumsq * 2^32, one root bit
// per register stage. Depends on rmrpy_pkg.
module rmrpy_isqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [rmrpy_pkg::SUMSQ_W-1:0]  sumsq,
  output logic [rmrpy_pkg::ROOT_W-1:0]   root
);
  import rmrpy_pkg::*;

  logic [SUMSQ_W-1:0] n_q [ISQ_STEPS+1];
  logic [ROOT_W-1:0]  q_q [ISQ_STEPS+1];
  logic [REM_W-1:0]   r_q [ISQ_STEPS+1];

  assign n_q[0] = sumsq;
  assign q_q[0] = '0;
  assign r_q[0] = '0;

  // restoring digit step: bring down two bits, try subtracting 4q+1
  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] d;
    logic             ge;
    assign t  = {r_q[k], n_q[k][SUMSQ_W-1 -: 2]};
    assign d  = {2'b00, q_q[k], 2'b01};
    assign ge = (t >= d);

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[k+1] <= {n_q[k][SUMSQ_W-3:0], 2'b00};
        if (ge) begin
          r_q[k+1] <= REM_W'(t - d);
          q_q[k+1] <= {q_q[k][ROOT_W-2:0], 1'b1};
        end else begin
          r_q[k+1] <= t[REM_W-1:0];
          q_q[k+1] <= {q_q[k][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = q_q[ISQ_STEPS];

endmodule

### hw/rtl/rmrpy_cordic.sv
// rmrpy_cordic: pipelined vectoring cordic atan2 on Q2.30 operands, with a
// half-plane pre-rotation stage and a round/saturate stage. Depends on rmrpy_pkg.
module rmrpy_cordic #(
  parameter int                     STEPS = rmrpy_pkg::CORDIC_STEPS_DEF,
  parameter logic signed [15:0]     LIM   = rmrpy_pkg::PI_Q13
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [rmrpy_pkg::IW-1:0]   y_in,
  input  logic signed [rmrpy_pkg::IW-1:0]   x_in,
  output logic signed [rmrpy_pkg::OW-1:0]   angle
);
  import rmrpy_pkg::*;

  logic signed [DW-1:0] x_q [STEPS+1];
  logic signed [DW-1:0] y_q [STEPS+1];
  logic signed [ZW-1:0] z_q [STEPS+1];

  logic signed [DW-1:0] xe;
  logic signed [DW-1:0] ye;
  assign xe = DW'(x_in);
  assign ye = DW'(y_in);

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      if (xe < 0) begin
        x_q[0] <= -xe;
        y_q[0] <= -ye;
        z_q[0] <= (ye >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        x_q[0] <= xe;
        y_q[0] <= ye;
        z_q[0] <= '0;
      end
    end
  end

  // one micro-rotation per stage, driving y toward zero
  for (genvar k = 0; k < STEPS; k++) begin : g_iter
    logic signed [DW-1:0] xs;
    logic signed [DW-1:0] ys;
    logic signed [ZW-1:0] at;
    assign xs = x_q[k] >>> k;
    assign ys = y_q[k] >>> k;
    assign at = ZW'(ATAN_TAB[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_q[k][DW-1]) begin
          x_q[k+1] <= x_q[k] + ys;
          y_q[k+1] <= y_q[k] - xs;
          z_q[k+1] <= z_q[k] + at;
        end else begin
          x_q[k+1] <= x_q[k] - ys;
          y_q[k+1] <= y_q[k] + xs;
          z_q[k+1] <= z_q[k] - at;
        end
      end
    end
  end

  // round to Q3.13 and clamp
  logic signed [ZW:0] zr;
  logic signed [ZW:0] zq;
  logic signed [ZW:0] lim_w;
  assign zr    = (ZW+1)'(z_q[STEPS]) + (ZW+1)'(65536);
  assign zq    = zr >>> 17;
  assign lim_w = (ZW+1)'(LIM);

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (zq > lim_w) begin
        angle <= LIM;
      end else if (zq < -lim_w) begin
        angle <= -LIM;
      end else begin
        angle <= zq[OW-1:0];
      end
    end
  end

endmodule

### hw/rtl/rotation_matrix_to_roll_pitch_yaw.sv
// Rotation matrix to roll/pitch/yaw (ZYX Euler angles) in Q3.13 radians,
// with pitch in Q2.13. Takes one matrix beat per cycle unless stalled and
// passes it through an input stage, a squaring stage, 32 square root stages
// (one root bit each) and three parallel cordic pipelines of
// CORDIC_STEPS + 2 stages. A stalled output freezes the whole pipeline, so
// in_stall follows out_stall while a result is waiting. A zero m00 or m22
// gives all-zero angles with degenerate set.
module rotation_matrix_to_roll_pitch_yaw #(
  parameter int CORDIC_STEPS = rmrpy_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [rmrpy_pkg::MW-1:0]    m00,
  input  logic signed [rmrpy_pkg::MW-1:0]    m10,
  input  logic signed [rmrpy_pkg::MW-1:0]    m20,
  input  logic signed [rmrpy_pkg::MW-1:0]    m21,
  input  logic signed [rmrpy_pkg::MW-1:0]    m22,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [15:0]                 roll_angle,
  output logic signed [14:0]                 pitch_angle,
  output logic signed [15:0]                 yaw_angle,
  output logic                               degenerate
);
  import rmrpy_pkg::*;

  localparam int LAT = 2 + ISQ_STEPS + CORDIC_STEPS + 2;

  logic en;
  logic vld [LAT];
  logic deg [LAT];

  // whole pipeline moves unless a finished beat is held
  assign en       = !vld[LAT-1] || !out_stall;
  assign in_stall = !en;

  // valid and degenerate flag travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg[0] <= (m00 == '0) || (m22 == '0);
      for (int i = 1; i < LAT; i++) deg[i] <= deg[i-1];
    end
  end

  // input stage
  mrow_t in_q;
  always_ff @(posedge clk) begin
    if (en) begin
      in_q <= '{m00: m00, m10: m10, m20: m20, m21: m21, m22: m22};
    end
  end

  // squaring stage, elements delayed to meet the root
  logic signed [2*MW-1:0] p21;
  logic signed [2*MW-1:0] p22;
  logic [SUMSQ_W-1:0]     sumsq_q;
  mrow_t                  dly [ISQ_STEPS+1];
  assign p21 = in_q.m21 * in_q.m21;
  assign p22 = in_q.m22 * in_q.m22;

  always_ff @(posedge clk) begin
    if (en) begin
      sumsq_q <= SUMSQ_W'(p21) + SUMSQ_W'(p22);
      dly[0]  <= in_q;
      for (int i = 1; i <= ISQ_STEPS; i++) dly[i] <= dly[i-1];
    end
  end

  logic [ROOT_W-1:0] root;
  rmrpy_isqrt u_isqrt (
    .clk   (clk),
    .en    (en),
    .sumsq (sumsq_q),
    .root  (root)
  );

  // Q2.30 operands
  mrow_t               mr;
  logic signed [IW-1:0] x00, y10, x22, y21, y20, xrt;
  assign mr  = dly[ISQ_STEPS];
  assign x00 = {mr.m00[MW-1], mr.m00, 16'h0000};
  assign y10 = {mr.m10[MW-1], mr.m10, 16'h0000};
  assign x22 = {mr.m22[MW-1], mr.m22, 16'h0000};
  assign y21 = {mr.m21[MW-1], mr.m21, 16'h0000};
  assign y20 = -{mr.m20[MW-1], mr.m20, 16'h0000};
  assign xrt = {1'b0, root};

  logic signed [OW-1:0] roll_c, pitch_c, yaw_c;

  rmrpy_cordic #(.STEPS(CORDIC_STEPS), .LIM(PI_Q13)) u_roll (
    .clk(clk), .en(en), .y_in(y21), .x_in(x22), .angle(roll_c)
  );
  rmrpy_cordic #(.STEPS(CORDIC_STEPS), .LIM(HALF_PI_Q13)) u_pitch (
    .clk(clk), .en(en), .y_in(y20), .x_in(xrt), .angle(pitch_c)
  );
  rmrpy_cordic #(.STEPS(CORDIC_STEPS), .LIM(PI_Q13)) u_yaw (
    .clk(clk), .en(en), .y_in(y10), .x_in(x00), .angle(yaw_c)
  );

  // output beat
  assign out_valid   = vld[LAT-1];
  assign degenerate  = deg[LAT-1];
  assign roll_angle  = deg[LAT-1] ? '0 : roll_c;
  assign pitch_angle = deg[LAT-1] ? '0 : pitch_c[14:0];
  assign yaw_angle   = deg[LAT-1] ? '0 : yaw_c;

  // held output beat blocks intake
  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("held output beat did not stall input");

  // pitch stays within a quarter turn
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868))
    else $error("pitch out of range");

  // roll and yaw stay within a half turn
  a_ry_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736 &&
                   yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736))
    else $error("roll or yaw out of range");

  // a stalled beat keeps its place in the pipe
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(roll_angle) &&
                                  $stable(yaw_angle) && $stable(degenerate)))
    else $error("held beat changed");

endmodule
